// ===== src/ps2mct_pkg.sv =====
// shared types, constants and helpers for the ps2 mouse packet cursor tracker
// no dependencies; used by every module of the block
`default_nettype none

package ps2mct_pkg;

	// coordinate width default and configuration register layout
	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_DATA_W     = 13;
	localparam int CFG_IDX_W      = 1;
	localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd480;

	// register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// header byte bits
	localparam int HDR_LEFT   = 0;
	localparam int HDR_RIGHT  = 1;
	localparam int HDR_MIDDLE = 2;
	localparam int HDR_MARK   = 3;
	localparam int HDR_XSIGN  = 4;
	localparam int HDR_YSIGN  = 5;
	localparam int HDR_XOVF   = 6;
	localparam int HDR_YOVF   = 7;

	// move width and overflow step
	localparam int MOVE_W = 10;
	localparam logic signed [MOVE_W-1:0] OVF_EXTRA = 10'sd255;

	// queue between parser and updater
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// one complete three-byte packet
	typedef struct packed {
		logic [7:0] header;
		logic [7:0] x_byte;
		logic [7:0] y_byte;
	} packet_t;

	// request from the parser into the queue
	typedef struct packed {
		logic    push;
		packet_t pkt;
	} push_req_t;

	// queue head toward the updater
	typedef struct packed {
		logic    valid;
		packet_t pkt;
	} queue_head_t;

	// ten-bit signed move with the overflow extra applied
	function automatic logic signed [MOVE_W-1:0] signed_move(
		input logic [7:0] b,
		input logic       neg,
		input logic       ovf
	);
		logic signed [MOVE_W-1:0] m;
		m = neg ? $signed({2'b11, b}) : $signed({2'b00, b});
		if (ovf) begin
			m = neg ? (m - OVF_EXTRA) : (m + OVF_EXTRA);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== src/ps2mct_front.sv =====
// byte parser: drops the first byte, finds headers, assembles three-byte packets
// depends on ps2mct_pkg
`default_nettype none

module ps2mct_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [7:0]            in_byte,
	input  wire                   queue_full,
	output ps2mct_pkg::push_req_t push_req
);

	// one-hot byte slot
	typedef enum logic [2:0] {
		SLOT_HEADER = 3'b001,
		SLOT_X      = 3'b010,
		SLOT_Y      = 3'b100
	} slot_t;

	slot_t      slot_q;
	logic       drop_first_q;
	logic [7:0] header_q;
	logic [7:0] x_byte_q;
	logic       accept;
	logic       work;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign work     = accept && !drop_first_q;

	// slot sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_first_q <= 1'b1;
			slot_q       <= SLOT_HEADER;
		end else if (accept) begin
			if (drop_first_q) begin
				drop_first_q <= 1'b0;
			end else begin
				case (slot_q)
					SLOT_X:  slot_q <= SLOT_Y;
					SLOT_Y:  slot_q <= SLOT_HEADER;
					default: slot_q <= in_byte[ps2mct_pkg::HDR_MARK] ? SLOT_X : SLOT_HEADER;
				endcase
			end
		end
	end

	// header and x move capture
	always_ff @(posedge clk) begin
		if (work && slot_q != SLOT_X && slot_q != SLOT_Y && in_byte[ps2mct_pkg::HDR_MARK]) begin
			header_q <= in_byte;
		end
		if (work && slot_q == SLOT_X) begin
			x_byte_q <= in_byte;
		end
	end

	// third byte completes the packet
	always_comb begin
		push_req.push       = work && (slot_q == SLOT_Y);
		push_req.pkt.header = header_q;
		push_req.pkt.x_byte = x_byte_q;
		push_req.pkt.y_byte = in_byte;
	end

endmodule

`default_nettype wire

// ===== src/ps2mct_queue.sv =====
// two-entry packet queue between the parser and the position updater
// depends on ps2mct_pkg
`default_nettype none

module ps2mct_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ps2mct_pkg::push_req_t   push_req,
	output logic                    full,
	output ps2mct_pkg::queue_head_t head,
	input  wire                     pop
);

	ps2mct_pkg::packet_t             mem_q [ps2mct_pkg::QUEUE_DEPTH];
	logic [ps2mct_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ps2mct_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ps2mct_pkg::QCNT_W-1:0]   count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (count_q == ps2mct_pkg::QCNT_W'(ps2mct_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.pkt   = mem_q[rd_ptr_q];
	assign do_push    = push_req.push && !full;
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_req.pkt;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// a packet is never offered while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_req.push |-> !full) else $error("packet pushed into full queue");

	// a pop is never requested on an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");

	// fill count stays within depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ps2mct_pkg::QCNT_W'(ps2mct_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== src/ps2mct_back.sv =====
// position updater: applies packet moves, clamps to the screen, holds the result register
// depends on ps2mct_pkg
`default_nettype none

module ps2mct_back #(
	parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ps2mct_pkg::queue_head_t head,
	output logic                    pop,
	input  wire  [COORD_BITS-1:0]   top_x,
	input  wire  [COORD_BITS-1:0]   top_y,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [COORD_BITS-1:0]   cursor_x,
	output logic [COORD_BITS-1:0]   cursor_y,
	output logic [2:0]              buttons
);

	localparam int BASE_W = (COORD_BITS > ps2mct_pkg::MOVE_W) ? COORD_BITS : ps2mct_pkg::MOVE_W;
	localparam int SUM_W  = BASE_W + 2;

	logic                                  out_valid_q;
	logic [COORD_BITS-1:0]                 pos_x_q;
	logic [COORD_BITS-1:0]                 pos_y_q;
	logic [2:0]                            buttons_q;
	logic signed [ps2mct_pkg::MOVE_W-1:0]  dx;
	logic signed [ps2mct_pkg::MOVE_W-1:0]  dy;
	logic signed [SUM_W-1:0]               sum_x;
	logic signed [SUM_W-1:0]               sum_y;
	logic [COORD_BITS-1:0]                 next_x;
	logic [COORD_BITS-1:0]                 next_y;
	logic [7:0]                            hdr;

	// clamp a signed sum to 0..top
	function automatic logic [COORD_BITS-1:0] clamp(
		input logic signed [SUM_W-1:0] v,
		input logic [COORD_BITS-1:0]   top
	);
		logic [COORD_BITS-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if ($unsigned(v) > SUM_W'(top)) begin
			r = top;
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

	assign pop = head.valid && (!out_valid_q || out_ready);
	assign hdr = head.pkt.header;

	// moves and new position
	always_comb begin
		dx = ps2mct_pkg::signed_move(head.pkt.x_byte, hdr[ps2mct_pkg::HDR_XSIGN],
			hdr[ps2mct_pkg::HDR_XOVF]);
		dy = ps2mct_pkg::signed_move(head.pkt.y_byte, hdr[ps2mct_pkg::HDR_YSIGN],
			hdr[ps2mct_pkg::HDR_YOVF]);
		sum_x  = $signed(SUM_W'(pos_x_q)) + SUM_W'(dx);
		sum_y  = $signed(SUM_W'(pos_y_q)) - SUM_W'(dy);
		next_x = clamp(sum_x, top_x);
		next_y = clamp(sum_y, top_y);
	end

	// cursor state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				pos_x_q     <= next_x;
				pos_y_q     <= next_y;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// button payload
	always_ff @(posedge clk) begin
		if (pop) begin
			buttons_q <= {hdr[ps2mct_pkg::HDR_MIDDLE], hdr[ps2mct_pkg::HDR_RIGHT],
				hdr[ps2mct_pkg::HDR_LEFT]};
		end
	end

	assign out_valid = out_valid_q;
	assign cursor_x  = pos_x_q;
	assign cursor_y  = pos_y_q;
	assign buttons   = buttons_q;

	// a held result is replaced only once it has been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q && $stable(pos_x_q) && $stable(pos_y_q))
		else $error("held result overwritten");

	// a taken result with nothing behind it leaves the register empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !head.valid) |=> !out_valid_q)
		else $error("result repeated");

	// every popped packet shows up as a result
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q) else $error("popped packet lost");

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_cursor_tracker.sv =====
// top level of the ps2 mouse packet cursor tracker: config registers, parser, queue, updater
// depends on ps2mct_pkg, ps2mct_front, ps2mct_queue, ps2mct_back
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: cursor_x, cursor_y, left, right, middle
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data (screen_width, screen_height)
//
// one byte is taken per cycle while the queue is not full; the third byte of a packet is written
// into the queue, then popped into the updater's result register when that register is empty or being taken
// reset: first byte dropped, cursor at 0,0, screen 640 by 480; no clearing pass
// the two-entry packet queue lets bytes keep flowing while a result waits on m_axis_tready;
// s_axis_tready falls only when the queue holds two packets
// cfg_ready is always high
`default_nettype none

module ps2_mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [7:0]                       s_axis_tdata,   // [7:0] rx_byte
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// cursor_x, cursor_y, left_button, right_button, middle_button from bit 0 up, zero padded
	output logic [((2*COORD_BITS+3+7)/8)*8-1:0] m_axis_tdata,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [ps2mct_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int OUT_W = ((2*COORD_BITS+3+7)/8)*8;
	localparam int PAD_W = OUT_W - (2*COORD_BITS+3);
	localparam int EXT_W = (COORD_BITS+1 > ps2mct_pkg::CFG_DATA_W) ?
		COORD_BITS+1 : ps2mct_pkg::CFG_DATA_W;
	localparam logic [EXT_W-1:0] SPAN = EXT_W'(1) << COORD_BITS;
	localparam logic [COORD_BITS-1:0] TOP_X_RST =
		(EXT_W'(ps2mct_pkg::WIDTH_RESET) > SPAN) ? {COORD_BITS{1'b1}} :
		COORD_BITS'(ps2mct_pkg::WIDTH_RESET - 1'b1);
	localparam logic [COORD_BITS-1:0] TOP_Y_RST =
		(EXT_W'(ps2mct_pkg::HEIGHT_RESET) > SPAN) ? {COORD_BITS{1'b1}} :
		COORD_BITS'(ps2mct_pkg::HEIGHT_RESET - 1'b1);

	logic                       queue_full;
	logic                       pop;
	ps2mct_pkg::push_req_t      push_req;
	ps2mct_pkg::queue_head_t    head;
	logic [COORD_BITS-1:0]      top_x_q;
	logic [COORD_BITS-1:0]      top_y_q;
	logic [COORD_BITS-1:0]      cfg_top;
	logic [EXT_W-1:0]           cfg_ext;
	logic [COORD_BITS-1:0]      cursor_x;
	logic [COORD_BITS-1:0]      cursor_y;
	logic [2:0]                 buttons;

	assign cfg_ready = 1'b1;

	// screen size to highest coordinate, zero acting as one and large sizes capped
	always_comb begin
		cfg_ext = EXT_W'(cfg_data);
		if (cfg_data == '0) begin
			cfg_top = '0;
		end else if (cfg_ext > SPAN) begin
			cfg_top = {COORD_BITS{1'b1}};
		end else begin
			cfg_top = COORD_BITS'(cfg_ext - 1'b1);
		end
	end

	// configuration registers kept as highest coordinate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_x_q <= TOP_X_RST;
			top_y_q <= TOP_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ps2mct_pkg::REG_SCREEN_WIDTH:  top_x_q <= cfg_top;
				ps2mct_pkg::REG_SCREEN_HEIGHT: top_y_q <= cfg_top;
				default:                       top_x_q <= top_x_q;
			endcase
		end
	end

	ps2mct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.queue_full (queue_full),
		.push_req   (push_req)
	);

	ps2mct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.full     (queue_full),
		.head     (head),
		.pop      (pop)
	);

	ps2mct_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.top_x     (top_x_q),
		.top_y     (top_y_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cursor_x  (cursor_x),
		.cursor_y  (cursor_y),
		.buttons   (buttons)
	);

	// result packing
	generate
		if (PAD_W > 0) begin : g_pad
			assign m_axis_tdata = {{PAD_W{1'b0}}, buttons, cursor_y, cursor_x};
		end else begin : g_nopad
			assign m_axis_tdata = {buttons, cursor_y, cursor_x};
		end
	endgenerate

endmodule

`default_nettype wire
